@@ src/sapd_pkg.sv @@
`timescale 1ns / 1ps
// package: codes, control word and microprogram of the servo pwm duty block
package sapd_pkg;

  // field widths
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PULSE_W = 14;
  localparam int PERIOD_W = 16;
  localparam int VALUE_W = 16;
  localparam int DUTY_W = 32;
  localparam int ANGLE_W = 8;
  localparam int STATUS_W = 2;
  localparam int FUNC_W = 2;

  // shared divider: 48-bit dividend, 16-bit divisor, one quotient bit per cycle
  localparam int DIV_W = 48;
  localparam int DIV_CNT_W = 6;

  // limits
  localparam int FULL_ANGLE = 180;
  localparam int HALF_ANGLE = 90;
  localparam int MAX_PULSE_LIMIT = 10000;

  // angle mapping quotient: n / 180 == ((n >> 2) * ANG_RECIP) >> ANG_RECIP_SH for n < 2**21
  localparam int ANG_RECIP_W = 20;
  localparam logic [ANG_RECIP_W-1:0] ANG_RECIP = 20'd745655;
  localparam int ANG_RECIP_SH = 25;

  // reset values of the registers
  localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 14'd544;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 14'd2400;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd20000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACHED = 2'd3;

  // command codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE_ANGLE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE_USEC = 2'd1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DETACHED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_CFG = 2'd2;

  // microprogram
  localparam int PC_W = 5;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_TAKE,
    OP_CHECK,
    OP_ANG_PREP,
    OP_ANG_DONE,
    OP_USEC,
    OP_DUTY_PREP,
    OP_DUTY_DONE,
    OP_READ_PREP,
    OP_READ_DONE,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_IN,
    C_ERR,
    C_READ,
    C_USEC,
    C_CLAMP,
    C_DIV_BUSY,
    C_CUR_LE_MIN,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ctrl_t;

  // step addresses
  localparam logic [PC_W-1:0] S_TAKE       = 5'd0;
  localparam logic [PC_W-1:0] S_CHECK      = 5'd1;
  localparam logic [PC_W-1:0] S_SEL_READ   = 5'd2;
  localparam logic [PC_W-1:0] S_SEL_USEC   = 5'd3;
  localparam logic [PC_W-1:0] S_ANG_PREP   = 5'd4;
  localparam logic [PC_W-1:0] S_ANG_WAIT   = 5'd5;
  localparam logic [PC_W-1:0] S_ANG_DONE   = 5'd6;
  localparam logic [PC_W-1:0] S_USEC       = 5'd7;
  localparam logic [PC_W-1:0] S_DUTY_PREP  = 5'd8;
  localparam logic [PC_W-1:0] S_DUTY_WAIT  = 5'd9;
  localparam logic [PC_W-1:0] S_DUTY_DONE  = 5'd10;
  localparam logic [PC_W-1:0] S_READ_TEST  = 5'd11;
  localparam logic [PC_W-1:0] S_READ_PREP  = 5'd12;
  localparam logic [PC_W-1:0] S_READ_WAIT  = 5'd13;
  localparam logic [PC_W-1:0] S_READ_DONE  = 5'd14;
  localparam logic [PC_W-1:0] S_OUT_WAIT   = 5'd15;
  localparam logic [PC_W-1:0] S_EMIT       = 5'd16;

  // control store
  function automatic ctrl_t rom_read(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      S_TAKE:      w = '{OP_TAKE,      C_NO_IN,      S_TAKE};
      S_CHECK:     w = '{OP_CHECK,     C_ERR,        S_OUT_WAIT};
      S_SEL_READ:  w = '{OP_NOP,       C_READ,       S_READ_TEST};
      S_SEL_USEC:  w = '{OP_NOP,       C_USEC,       S_USEC};
      S_ANG_PREP:  w = '{OP_ANG_PREP,  C_CLAMP,      S_DUTY_PREP};
      S_ANG_WAIT:  w = '{OP_NOP,       C_NEXT,       S_TAKE};
      S_ANG_DONE:  w = '{OP_ANG_DONE,  C_ALWAYS,     S_DUTY_PREP};
      S_USEC:      w = '{OP_USEC,      C_NEXT,       S_TAKE};
      S_DUTY_PREP: w = '{OP_DUTY_PREP, C_NEXT,       S_TAKE};
      S_DUTY_WAIT: w = '{OP_NOP,       C_DIV_BUSY,   S_DUTY_WAIT};
      S_DUTY_DONE: w = '{OP_DUTY_DONE, C_ALWAYS,     S_OUT_WAIT};
      S_READ_TEST: w = '{OP_NOP,       C_CUR_LE_MIN, S_OUT_WAIT};
      S_READ_PREP: w = '{OP_READ_PREP, C_NEXT,       S_TAKE};
      S_READ_WAIT: w = '{OP_NOP,       C_DIV_BUSY,   S_READ_WAIT};
      S_READ_DONE: w = '{OP_READ_DONE, C_NEXT,       S_TAKE};
      S_OUT_WAIT:  w = '{OP_NOP,       C_OUT_FULL,   S_OUT_WAIT};
      S_EMIT:      w = '{OP_EMIT,      C_ALWAYS,     S_TAKE};
      default:     w = '{OP_NOP,       C_ALWAYS,     S_TAKE};
    endcase
    return w;
  endfunction

endpackage

@@ src/servo_angle_to_pwm_duty_top.sv @@
`timescale 1ns / 1ps
// top level: microcoded servo command unit producing pwm duty, pulse and angle
//
// One command is in flight at a time. Commands that end in an error or in a read of a
// pulse at or below the minimum skip the divider; the others use the shared restoring
// divider, which gives one of 48 quotient bits per cycle for the duty fraction and the
// read angle, while the angle mapping divides by 180 with a reciprocal multiplication.
// A stalled result adds its stall cycles at the output step of the next command.
// A finished result sits in the output register while the next command is taken in.
// Configuration is written through cfg_* (always ready); the user must write it only
// while no command is in flight, since the block itself does not enforce this.
module servo_angle_to_pwm_duty_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // command channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sapd_pkg::FUNC_W-1:0]         in_func,
  input  logic signed [sapd_pkg::VALUE_W-1:0] in_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sapd_pkg::STATUS_W-1:0]       out_status,
  output logic [sapd_pkg::DUTY_W-1:0]         out_duty_cycle,
  output logic [sapd_pkg::PULSE_W-1:0]        out_pulse_us,
  output logic [sapd_pkg::ANGLE_W-1:0]        out_angle,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sapd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sapd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int PW = sapd_pkg::PULSE_W;
  localparam int DW = sapd_pkg::DIV_W;
  localparam int PRW = sapd_pkg::PERIOD_W;

  // configuration and state
  logic [PW-1:0]  min_r, min_nxt;
  logic [PW-1:0]  max_r, max_nxt;
  logic [PRW-1:0] period_r, period_nxt;
  logic           attached_r, attached_nxt;
  logic [PW-1:0]  cur_r, cur_nxt;

  // sequencer
  logic [sapd_pkg::PC_W-1:0] pc_r, pc_nxt;
  sapd_pkg::ctrl_t           cw;
  logic                      cond_hit;

  // command and work registers
  logic [sapd_pkg::FUNC_W-1:0]         func_r, func_nxt;
  logic signed [sapd_pkg::VALUE_W-1:0] value_r, value_nxt;
  logic [PW-1:0]                       pulse_r, pulse_nxt;
  logic [sapd_pkg::STATUS_W-1:0]       status_r, status_nxt;
  logic [sapd_pkg::DUTY_W-1:0]         duty_r, duty_nxt;
  logic [sapd_pkg::ANGLE_W-1:0]        angle_r, angle_nxt;

  // divider
  logic [DW-1:0]                   dq_r, dq_nxt;
  logic [PRW-1:0]                  rem_r, rem_nxt;
  logic [PRW-1:0]                  den_r, den_nxt;
  logic [sapd_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                            div_busy;
  logic [PRW:0]                    div_trial;
  logic                            div_ge;
  logic [PRW:0]                    div_diff;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic [sapd_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [sapd_pkg::DUTY_W-1:0]   out_duty_r, out_duty_nxt;
  logic [PW-1:0]                 out_pulse_r, out_pulse_nxt;
  logic [sapd_pkg::ANGLE_W-1:0]  out_angle_r, out_angle_nxt;

  // decoded conditions and datapath terms
  logic          cfg_ok;
  logic          is_read;
  logic          is_usec;
  logic [sapd_pkg::STATUS_W-1:0] chk_status;
  logic [PW-1:0] range;
  logic          ang_low;
  logic          ang_high;
  logic [21:0]   ang_prod;
  logic [38:0]   ang_recip;
  logic [PW-1:0] cur_off;
  logic [21:0]   rd_prod;
  logic signed [sapd_pkg::VALUE_W-1:0] min_s;
  logic signed [sapd_pkg::VALUE_W-1:0] max_s;
  logic          in_take;

  assign cw = sapd_pkg::rom_read(pc_r);

  // configuration sanity and command checks
  always_comb begin
    cfg_ok = (max_r > min_r) && ({18'd0, max_r} <= 32'(sapd_pkg::MAX_PULSE_LIMIT))
             && (period_r != '0);
    is_read = func_r[1];
    is_usec = (func_r == sapd_pkg::FUNC_WRITE_USEC);
    if (!is_read && !attached_r) begin
      chk_status = sapd_pkg::ST_DETACHED;
    end else if (!cfg_ok) begin
      chk_status = sapd_pkg::ST_BAD_CFG;
    end else begin
      chk_status = sapd_pkg::ST_OK;
    end
  end

  // arithmetic terms
  always_comb begin
    range = max_r - min_r;
    ang_low = (value_r <= 16'sd0);
    ang_high = (value_r >= 16'(sapd_pkg::FULL_ANGLE));
    ang_prod = 22'(range) * 22'(value_r[7:0]);
    // quotient by 180 of the registered mapping dividend, which stays below 2**21
    ang_recip = 39'(dq_r[20:2]) * 39'(sapd_pkg::ANG_RECIP);
    cur_off = cur_r - min_r;
    rd_prod = 22'(cur_off) * 22'(sapd_pkg::FULL_ANGLE);
    min_s = $signed({2'b00, min_r});
    max_s = $signed({2'b00, max_r});
  end

  // divider step
  always_comb begin
    div_busy = (cnt_r != '0);
    div_trial = {rem_r, dq_r[DW-1]};
    div_ge = (div_trial >= {1'b0, den_r});
    div_diff = div_trial - {1'b0, den_r};
  end

  // jump conditions
  always_comb begin
    case (cw.cond)
      sapd_pkg::C_NEXT:       cond_hit = 1'b0;
      sapd_pkg::C_ALWAYS:     cond_hit = 1'b1;
      sapd_pkg::C_NO_IN:      cond_hit = !in_valid;
      sapd_pkg::C_ERR:        cond_hit = (chk_status != sapd_pkg::ST_OK);
      sapd_pkg::C_READ:       cond_hit = is_read;
      sapd_pkg::C_USEC:       cond_hit = is_usec;
      sapd_pkg::C_CLAMP:      cond_hit = ang_low || ang_high;
      sapd_pkg::C_DIV_BUSY:   cond_hit = div_busy;
      sapd_pkg::C_CUR_LE_MIN: cond_hit = (cur_r <= min_r);
      sapd_pkg::C_OUT_FULL:   cond_hit = out_valid_r && out_stall;
      default:                cond_hit = 1'b0;
    endcase
  end

  assign in_take = (cw.op == sapd_pkg::OP_TAKE);

  // next state of sequencer and datapath
  always_comb begin
    pc_nxt = cond_hit ? cw.target : pc_r + 1'b1;

    min_nxt = min_r;
    max_nxt = max_r;
    period_nxt = period_r;
    attached_nxt = attached_r;
    cur_nxt = cur_r;
    func_nxt = func_r;
    value_nxt = value_r;
    pulse_nxt = pulse_r;
    status_nxt = status_r;
    duty_nxt = duty_r;
    angle_nxt = angle_r;
    dq_nxt = dq_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_duty_nxt = out_duty_r;
    out_pulse_nxt = out_pulse_r;
    out_angle_nxt = out_angle_r;

    // configuration writes
    if (cfg_valid) begin
      case (cfg_index)
        sapd_pkg::REG_MIN_PULSE: min_nxt = cfg_data[PW-1:0];
        sapd_pkg::REG_MAX_PULSE: max_nxt = cfg_data[PW-1:0];
        sapd_pkg::REG_PERIOD:    period_nxt = cfg_data;
        sapd_pkg::REG_ATTACHED:  attached_nxt = cfg_data[0];
        default: ;
      endcase
    end

    // one quotient bit per cycle
    if (div_busy) begin
      rem_nxt = div_ge ? div_diff[PRW-1:0] : div_trial[PRW-1:0];
      dq_nxt = {dq_r[DW-2:0], div_ge};
      cnt_nxt = cnt_r - 1'b1;
    end

    case (cw.op)
      sapd_pkg::OP_TAKE: begin
        if (in_valid) begin
          func_nxt = in_func;
          value_nxt = in_value;
          duty_nxt = '0;
          angle_nxt = '0;
        end
      end
      sapd_pkg::OP_CHECK: status_nxt = chk_status;
      sapd_pkg::OP_ANG_PREP: begin
        if (ang_low) begin
          pulse_nxt = min_r;
        end else if (ang_high) begin
          pulse_nxt = max_r;
        end else begin
          dq_nxt = DW'(ang_prod) + DW'(sapd_pkg::HALF_ANGLE);
        end
      end
      sapd_pkg::OP_ANG_DONE: pulse_nxt = ang_recip[sapd_pkg::ANG_RECIP_SH +: PW] + min_r;
      sapd_pkg::OP_USEC: begin
        if (value_r < min_s) begin
          pulse_nxt = min_r;
        end else if (value_r > max_s) begin
          pulse_nxt = max_r;
        end else begin
          pulse_nxt = value_r[PW-1:0];
        end
      end
      sapd_pkg::OP_DUTY_PREP: begin
        // pulse * 0xFFFFFFFF + period / 2
        dq_nxt = {2'b00, pulse_r, 32'd0} - DW'(pulse_r) + DW'(period_r[PRW-1:1]);
        den_nxt = period_r;
        rem_nxt = '0;
        cnt_nxt = sapd_pkg::DIV_CNT_W'(DW);
      end
      sapd_pkg::OP_DUTY_DONE: begin
        duty_nxt = (dq_r[DW-1:32] != '0) ? '1 : dq_r[31:0];
        cur_nxt = pulse_r;
      end
      sapd_pkg::OP_READ_PREP: begin
        dq_nxt = DW'(rd_prod) + DW'(range[PW-1:1]);
        den_nxt = {2'b00, range};
        rem_nxt = '0;
        cnt_nxt = sapd_pkg::DIV_CNT_W'(DW);
      end
      sapd_pkg::OP_READ_DONE: begin
        angle_nxt = (dq_r > DW'(sapd_pkg::FULL_ANGLE)) ?
                    sapd_pkg::ANGLE_W'(sapd_pkg::FULL_ANGLE) : dq_r[sapd_pkg::ANGLE_W-1:0];
      end
      sapd_pkg::OP_EMIT: begin
        out_valid_nxt = 1'b1;
        out_status_nxt = status_r;
        out_duty_nxt = duty_r;
        out_pulse_nxt = cur_r;
        out_angle_nxt = angle_r;
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= sapd_pkg::S_TAKE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      min_r <= sapd_pkg::MIN_PULSE_RST;
      max_r <= sapd_pkg::MAX_PULSE_RST;
      period_r <= sapd_pkg::PERIOD_RST;
      attached_r <= 1'b0;
      cur_r <= '0;
    end else begin
      pc_r <= pc_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      min_r <= min_nxt;
      max_r <= max_nxt;
      period_r <= period_nxt;
      attached_r <= attached_nxt;
      cur_r <= cur_nxt;
    end
    func_r <= func_nxt;
    value_r <= value_nxt;
    pulse_r <= pulse_nxt;
    status_r <= status_nxt;
    duty_r <= duty_nxt;
    angle_r <= angle_nxt;
    dq_r <= dq_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    out_status_r <= out_status_nxt;
    out_duty_r <= out_duty_nxt;
    out_pulse_r <= out_pulse_nxt;
    out_angle_r <= out_angle_nxt;
  end

  // ports
  assign in_stall = !in_take;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_duty_cycle = out_duty_r;
  assign out_pulse_us = out_pulse_r;
  assign out_angle = out_angle_r;

endmodule

@@ src/sapd_checker.sv @@
`timescale 1ns / 1ps
// checker: port-level properties of the servo pwm duty block, bound to the top level
module sapd_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [sapd_pkg::STATUS_W-1:0]       out_status,
  input logic [sapd_pkg::DUTY_W-1:0]         out_duty_cycle,
  input logic [sapd_pkg::PULSE_W-1:0]        out_pulse_us,
  input logic [sapd_pkg::ANGLE_W-1:0]        out_angle
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_duty_cycle) && $stable(out_angle)
                               && $stable(out_status) && $stable(out_pulse_us))
    else $error("stalled result beat changed");

  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // error beats carry no duty and no angle
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != sapd_pkg::ST_OK) |-> (out_duty_cycle == '0) && (out_angle == '0))
    else $error("error beat with duty or angle");

  // a beat never carries both a duty and an angle, and angle stays in range
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_duty_cycle == '0) || (out_angle == '0))
                  && (out_angle <= sapd_pkg::ANGLE_W'(sapd_pkg::FULL_ANGLE)))
    else $error("beat mixes duty and angle or angle out of range");

  // right after a command is accepted, the input is stalled
  a_no_double_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on two cycles in a row");

endmodule

bind servo_angle_to_pwm_duty_top sapd_checker u_sapd_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_status(out_status),
  .out_duty_cycle(out_duty_cycle),
  .out_pulse_us(out_pulse_us),
  .out_angle(out_angle)
);

@@ tb/sv/tb_servo_angle_to_pwm_duty_top.sv @@
`timescale 1ns / 1ps
// testbench: servo command to pwm duty block, checked against a cycle-free predictor
module tb_servo_angle_to_pwm_duty_top;

  localparam logic [sapd_pkg::FUNC_W-1:0] FUNC_READ_ANGLE = 2'd2;
  localparam logic [sapd_pkg::FUNC_W-1:0] FUNC_READ_SPARE = 2'd3;
  localparam longint DUTY_FULL = 64'h0000_0000_FFFF_FFFF;
  localparam int QUIET_LIMIT = 5000;
  localparam int SEG_ITEMS = 40;
  localparam int SEG_COUNT = 14;
  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    logic [sapd_pkg::STATUS_W-1:0] status;
    logic [sapd_pkg::DUTY_W-1:0]   duty;
    logic [sapd_pkg::PULSE_W-1:0]  pulse;
    logic [sapd_pkg::ANGLE_W-1:0]  angle;
  } servo_result_t;

  // predictor: register copy, held pulse and the results still owed by the block
  class servo_duty_predictor;
    int min_us = 544;
    int max_us = 2400;
    int period_us = 20000;
    bit attached = 1'b0;
    int held_pulse = 0;
    int mismatches = 0;
    servo_result_t pending_results[$];

    task report(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    function bit cfg_ok();
      return (max_us >= min_us + 1) && (max_us <= sapd_pkg::MAX_PULSE_LIMIT)
             && (period_us != 0);
    endfunction

    function void write_reg(input logic [sapd_pkg::CFG_IDX_W-1:0] idx,
                            input logic [sapd_pkg::CFG_DATA_W-1:0] d);
      case (idx)
        sapd_pkg::REG_MIN_PULSE: min_us = int'(d[sapd_pkg::PULSE_W-1:0]);
        sapd_pkg::REG_MAX_PULSE: max_us = int'(d[sapd_pkg::PULSE_W-1:0]);
        sapd_pkg::REG_PERIOD:    period_us = int'(d);
        sapd_pkg::REG_ATTACHED:  attached = d[0];
        default: ;
      endcase
    endfunction

    // work out the result of one command and update the held pulse
    function void accept_cmd(input logic [sapd_pkg::FUNC_W-1:0] f,
                             input logic signed [sapd_pkg::VALUE_W-1:0] v);
      servo_result_t r;
      int cmd_val;
      longint pulse;
      longint duty;
      longint span;
      longint ang;
      cmd_val = v;
      r.status = sapd_pkg::ST_OK;
      r.duty = '0;
      r.angle = '0;
      if (f == sapd_pkg::FUNC_WRITE_ANGLE || f == sapd_pkg::FUNC_WRITE_USEC) begin
        if (!attached) begin
          r.status = sapd_pkg::ST_DETACHED;
        end else if (!cfg_ok()) begin
          r.status = sapd_pkg::ST_BAD_CFG;
        end else begin
          if (f == sapd_pkg::FUNC_WRITE_ANGLE) begin
            if (cmd_val <= 0) pulse = min_us;
            else if (cmd_val >= sapd_pkg::FULL_ANGLE) pulse = max_us;
            else pulse = (longint'(max_us - min_us) * cmd_val + sapd_pkg::HALF_ANGLE)
                         / sapd_pkg::FULL_ANGLE + min_us;
          end else begin
            if (cmd_val < min_us) pulse = min_us;
            else if (cmd_val > max_us) pulse = max_us;
            else pulse = cmd_val;
          end
          duty = (pulse * DUTY_FULL + period_us / 2) / period_us;
          if (duty > DUTY_FULL) duty = DUTY_FULL;
          r.duty = duty[sapd_pkg::DUTY_W-1:0];
          held_pulse = int'(pulse) & 16'h3FFF;
        end
      end else begin
        if (!cfg_ok()) begin
          r.status = sapd_pkg::ST_BAD_CFG;
        end else if (held_pulse > min_us) begin
          span = max_us - min_us;
          ang = (longint'(held_pulse - min_us) * sapd_pkg::FULL_ANGLE + span / 2) / span;
          if (ang > sapd_pkg::FULL_ANGLE) ang = sapd_pkg::FULL_ANGLE;
          r.angle = ang[sapd_pkg::ANGLE_W-1:0];
        end
      end
      r.pulse = held_pulse[sapd_pkg::PULSE_W-1:0];
      pending_results.push_back(r);
    endfunction

    // compare one result beat with the oldest owed result
    task check_result(input servo_result_t got);
      servo_result_t want;
      if (pending_results.size() == 0) begin
        report("result beat with nothing owed");
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          report($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.duty !== want.duty)
          report($sformatf("duty_cycle got %h want %h", got.duty, want.duty));
        if (got.pulse !== want.pulse)
          report($sformatf("pulse_us got %0d want %0d", got.pulse, want.pulse));
        if (got.angle !== want.angle)
          report($sformatf("angle got %0d want %0d", got.angle, want.angle));
      end
    endtask
  endclass

  logic                                 clk;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_stall;
  logic [sapd_pkg::FUNC_W-1:0]          in_func;
  logic signed [sapd_pkg::VALUE_W-1:0]  in_value;
  logic                                 out_valid;
  logic                                 out_stall;
  logic [sapd_pkg::STATUS_W-1:0]        out_status;
  logic [sapd_pkg::DUTY_W-1:0]          out_duty_cycle;
  logic [sapd_pkg::PULSE_W-1:0]         out_pulse_us;
  logic [sapd_pkg::ANGLE_W-1:0]         out_angle;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [sapd_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [sapd_pkg::CFG_DATA_W-1:0]      cfg_data;

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int quiet_cycles = 0;
  servo_duty_predictor pred = new();

  servo_angle_to_pwm_duty_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_duty_cycle(out_duty_cycle),
    .out_pulse_us(out_pulse_us),
    .out_angle(out_angle),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < out_stall_pct);
  end

  // beat monitor on all three channels
  always @(posedge clk) begin
    servo_result_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.status = out_status;
        got.duty = out_duty_cycle;
        got.pulse = out_pulse_us;
        got.angle = out_angle;
        pred.check_result(got);
      end
      if (in_valid && !in_stall) pred.accept_cmd(in_func, in_value);
      if (cfg_valid && cfg_ready) pred.write_reg(cfg_index, cfg_data);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // one command beat, with random gaps ahead of it
  task automatic send_cmd(input logic [sapd_pkg::FUNC_W-1:0] f,
                          input logic signed [sapd_pkg::VALUE_W-1:0] v);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_func = f;
    in_value = v;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // stop sending and wait until every owed result has come back
  task automatic wait_results_done();
    in_valid = 1'b0;
    while (pred.pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [sapd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sapd_pkg::CFG_DATA_W-1:0] d);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // random register set, mostly valid, sometimes broken or at the edges
  task automatic pick_config();
    int lo;
    int hi;
    int per;
    int r;
    r = $urandom_range(99);
    if (r < 8) begin
      lo = $urandom_range(16383);
      hi = $urandom_range(16383);
    end else if (r < 20) begin
      lo = 0;
      hi = sapd_pkg::MAX_PULSE_LIMIT;
    end else if (r < 30) begin
      lo = $urandom_range(sapd_pkg::MAX_PULSE_LIMIT - 1);
      hi = lo + 1;
    end else if (r < 55) begin
      lo = $urandom_range(sapd_pkg::MAX_PULSE_LIMIT - 1);
      hi = $urandom_range(sapd_pkg::MAX_PULSE_LIMIT, lo + 1);
    end else begin
      lo = $urandom_range(1000, 400);
      hi = $urandom_range(2600, 2000);
    end
    r = $urandom_range(99);
    if (r < 5) per = 0;
    else if (r < 20) per = $urandom_range(3000, 1);
    else if (r < 30) per = 65535;
    else per = $urandom_range(65535, 1000);
    write_reg(sapd_pkg::REG_MIN_PULSE, lo[sapd_pkg::CFG_DATA_W-1:0]);
    write_reg(sapd_pkg::REG_MAX_PULSE, hi[sapd_pkg::CFG_DATA_W-1:0]);
    write_reg(sapd_pkg::REG_PERIOD, per[sapd_pkg::CFG_DATA_W-1:0]);
    write_reg(sapd_pkg::REG_ATTACHED, ($urandom_range(9) != 0) ? 16'd1 : 16'd0);
  endtask

  // random command value, mostly near the useful range of the command
  function automatic logic signed [sapd_pkg::VALUE_W-1:0] pick_value(
      input logic [sapd_pkg::FUNC_W-1:0] f);
    int r;
    int span;
    int v;
    r = $urandom_range(99);
    span = pred.max_us - pred.min_us;
    if (span < 0) span = 0;
    if (r < 20) v = $urandom_range(65535);
    else if (f == sapd_pkg::FUNC_WRITE_ANGLE) v = int'($urandom_range(200)) - 10;
    else if (r < 70) v = int'($urandom_range(span + 100)) + pred.min_us - 50;
    else v = int'($urandom_range(10600)) - 300;
    return v[sapd_pkg::VALUE_W-1:0];
  endfunction

  task automatic send_random_cmd();
    int r;
    logic [sapd_pkg::FUNC_W-1:0] f;
    r = $urandom_range(99);
    if (r < 35) f = sapd_pkg::FUNC_WRITE_ANGLE;
    else if (r < 70) f = sapd_pkg::FUNC_WRITE_USEC;
    else if (r < 95) f = FUNC_READ_ANGLE;
    else f = FUNC_READ_SPARE;
    send_cmd(f, pick_value(f));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = sapd_pkg::FUNC_WRITE_ANGLE;
    in_value = '0;
    cfg_valid = 1'b0;
    cfg_index = sapd_pkg::REG_MIN_PULSE;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings, output detached: read of a pulse below minimum, refused writes
    send_cmd(FUNC_READ_ANGLE, 16'sd0);
    send_cmd(sapd_pkg::FUNC_WRITE_ANGLE, 16'sd90);
    send_cmd(sapd_pkg::FUNC_WRITE_USEC, 16'sd1500);
    wait_results_done();
    write_reg(sapd_pkg::REG_ATTACHED, 16'd1);

    // angle and pulse extremes, clamping, both read selectors
    send_cmd(sapd_pkg::FUNC_WRITE_ANGLE, -16'sd32768);
    send_cmd(sapd_pkg::FUNC_WRITE_ANGLE, 16'sd0);
    send_cmd(sapd_pkg::FUNC_WRITE_ANGLE, 16'sd1);
    send_cmd(sapd_pkg::FUNC_WRITE_ANGLE, 16'sd90);
    send_cmd(sapd_pkg::FUNC_WRITE_ANGLE, 16'sd179);
    send_cmd(sapd_pkg::FUNC_WRITE_ANGLE, 16'sd180);
    send_cmd(sapd_pkg::FUNC_WRITE_ANGLE, 16'sd32767);
    send_cmd(sapd_pkg::FUNC_WRITE_USEC, -16'sd32768);
    send_cmd(sapd_pkg::FUNC_WRITE_USEC, 16'sd32767);
    send_cmd(sapd_pkg::FUNC_WRITE_USEC, 16'sd1500);
    send_cmd(FUNC_READ_ANGLE, 16'sd0);
    send_cmd(FUNC_READ_SPARE, -16'sd1);

    // held pulse below a raised minimum reads as angle zero
    wait_results_done();
    write_reg(sapd_pkg::REG_MIN_PULSE, 16'd2000);
    send_cmd(FUNC_READ_ANGLE, 16'sd0);

    // held pulse above a lowered maximum saturates the angle
    wait_results_done();
    write_reg(sapd_pkg::REG_MIN_PULSE, 16'd544);
    write_reg(sapd_pkg::REG_MAX_PULSE, 16'd1000);
    send_cmd(FUNC_READ_ANGLE, 16'sd0);

    // zero period
    wait_results_done();
    write_reg(sapd_pkg::REG_PERIOD, 16'd0);
    send_cmd(sapd_pkg::FUNC_WRITE_ANGLE, 16'sd45);
    send_cmd(FUNC_READ_ANGLE, 16'sd0);

    // maximum over the hard limit
    wait_results_done();
    write_reg(sapd_pkg::REG_PERIOD, 16'd1);
    write_reg(sapd_pkg::REG_MAX_PULSE, 16'd12000);
    send_cmd(sapd_pkg::FUNC_WRITE_USEC, 16'sd700);

    // empty range
    wait_results_done();
    write_reg(sapd_pkg::REG_MAX_PULSE, 16'd544);
    send_cmd(FUNC_READ_ANGLE, 16'sd0);

    // widest range with a tiny period saturates the duty
    wait_results_done();
    write_reg(sapd_pkg::REG_MIN_PULSE, 16'd0);
    write_reg(sapd_pkg::REG_MAX_PULSE, 16'd10000);
    send_cmd(sapd_pkg::FUNC_WRITE_USEC, 16'sd10000);

    // narrowest range at the top, longest period
    wait_results_done();
    write_reg(sapd_pkg::REG_MIN_PULSE, 16'd9999);
    write_reg(sapd_pkg::REG_PERIOD, 16'd65535);
    send_cmd(sapd_pkg::FUNC_WRITE_ANGLE, 16'sd90);
    send_cmd(FUNC_READ_ANGLE, 16'sd0);

    // random segments under three idle patterns
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          in_idle_pct = 15;
          out_stall_pct = 88;
        end
        1: begin
          in_idle_pct = 88;
          out_stall_pct = 15;
        end
        default: begin
          in_idle_pct = 0;
          out_stall_pct = 0;
        end
      endcase
      for (int seg = 0; seg < SEG_COUNT; seg++) begin
        wait_results_done();
        pick_config();
        repeat (SEG_ITEMS) send_random_cmd();
      end
    end

    // drain and settle
    wait_results_done();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pred.pending_results.size() != 0) pred.report("results still owed at the end");
    if (pred.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
